[rtl/osc_message_parser_assert.svh]
// Assertion macros shared by the osc_message_parser checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef OSC_MESSAGE_PARSER_ASSERT_SVH
`define OSC_MESSAGE_PARSER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define OSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("osc_message_parser: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define OSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("osc_message_parser: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define OSC_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("osc_message_parser: reset check failed");

`endif

[rtl/omp_pkg.sv]
// Shared types and constants for the OSC message parser.
// No dependencies; used by every RTL file of the block.
package omp_pkg;

  localparam int MAX_PACKET_BYTES = 65536;
  localparam int MAX_TAGS         = 16;

  localparam int BCNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int TCNT_W = $clog2(MAX_TAGS + 1);
  localparam int TIDX_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_S     = 8'h73;

  typedef enum logic [2:0] {
    PH_ADDR     = 3'd0,
    PH_ADDR_PAD = 3'd1,
    PH_COMMA    = 3'd2,
    PH_TAGS     = 3'd3,
    PH_ARG_PAD  = 3'd4,
    PH_ARGS     = 3'd5,
    PH_STRING   = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_ADDR_BYTE = 3'd0,
    K_ADDR_END  = 3'd1,
    K_INT       = 3'd2,
    K_FLOAT     = 3'd3,
    K_STR_BYTE  = 3'd4,
    K_STR_END   = 3'd5,
    K_VERDICT   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    V_OK        = 2'd0,
    V_TOO_SHORT = 2'd1,
    V_BAD_ADDR  = 2'd2,
    V_OVERFLOW  = 2'd3
  } verd_t;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_I    = 2'd1,
    TAG_F    = 2'd2,
    TAG_S    = 2'd3
  } tag_t;

  // Results caused by one packet byte: an optional argument-side result
  // followed by an optional verdict.
  typedef struct packed {
    logic        has_arg;
    kind_t       kind;
    logic [31:0] value;
    logic        has_verd;
    verd_t       verdict;
  } ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/omp_front.sv]
// Front end: takes packet bytes, tracks the OSC parse phase and tag list,
// and builds at most one queue entry per byte. Depends on omp_pkg.
module omp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc_in,
  input  logic [7:0]        byte_in,
  input  logic              eop_in,
  output logic              push,
  output omp_pkg::ev_t      ev
);

  omp_pkg::phase_t             phase_r, phase_nxt, ph_eff;
  logic [omp_pkg::BCNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic [omp_pkg::TCNT_W-1:0]  total_r, total_nxt;
  logic [omp_pkg::TCNT_W-1:0]  cursor_r, cursor_nxt;
  logic [31:0]                 acc_r, acc_nxt;
  logic                        addr_ne_r, addr_ne_nxt;
  omp_pkg::verd_t              fault_r, fault_nxt;

  omp_pkg::tag_t               tag_store [omp_pkg::MAX_TAGS];
  logic                        tag_we;
  omp_pkg::tag_t               tag_wdata;
  omp_pkg::tag_t               tag_rd;
  omp_pkg::tag_t               code;
  logic                        take;
  logic [1:0]                  idx;

  assign take   = bcnt_r < omp_pkg::BCNT_W'(omp_pkg::MAX_PACKET_BYTES);
  assign idx    = bcnt_r[1:0];
  assign tag_rd = tag_store[cursor_r[omp_pkg::TIDX_W-1:0]];

  always_comb begin
    case (byte_in)
      omp_pkg::CH_I: code = omp_pkg::TAG_I;
      omp_pkg::CH_F: code = omp_pkg::TAG_F;
      omp_pkg::CH_S: code = omp_pkg::TAG_S;
      default:       code = omp_pkg::TAG_NONE;
    endcase
  end

  always_comb begin
    ph_eff = phase_r;
    if (phase_r == omp_pkg::PH_ADDR_PAD && idx == 2'b00) ph_eff = omp_pkg::PH_COMMA;
    if (phase_r == omp_pkg::PH_ARG_PAD && idx == 2'b00) ph_eff = omp_pkg::PH_ARGS;

    phase_nxt   = phase_r;
    bcnt_nxt    = bcnt_r;
    total_nxt   = total_r;
    cursor_nxt  = cursor_r;
    acc_nxt     = acc_r;
    addr_ne_nxt = addr_ne_r;
    fault_nxt   = fault_r;
    tag_we      = 1'b0;
    tag_wdata   = code;
    ev          = '0;

    if (acc_in && take) begin
      bcnt_nxt  = bcnt_r + 1'b1;
      phase_nxt = ph_eff;
      case (ph_eff)
        omp_pkg::PH_ADDR: begin
          if (byte_in != 8'h00) begin
            ev.has_arg  = 1'b1;
            ev.kind     = omp_pkg::K_ADDR_BYTE;
            ev.value    = {24'h0, byte_in};
            addr_ne_nxt = 1'b1;
          end else if (!addr_ne_r) begin
            fault_nxt = omp_pkg::V_BAD_ADDR;
            phase_nxt = omp_pkg::PH_DONE;
          end else begin
            ev.has_arg = 1'b1;
            ev.kind    = omp_pkg::K_ADDR_END;
            phase_nxt  = omp_pkg::PH_ADDR_PAD;
          end
        end
        omp_pkg::PH_COMMA: begin
          phase_nxt = (byte_in == omp_pkg::CH_COMMA) ? omp_pkg::PH_TAGS : omp_pkg::PH_DONE;
        end
        omp_pkg::PH_TAGS: begin
          if (byte_in == 8'h00) begin
            phase_nxt = omp_pkg::PH_ARG_PAD;
          end else if (code != omp_pkg::TAG_NONE) begin
            if (total_r < omp_pkg::TCNT_W'(omp_pkg::MAX_TAGS)) begin
              tag_we    = 1'b1;
              total_nxt = total_r + 1'b1;
            end else if (fault_r == omp_pkg::V_OK) begin
              fault_nxt = omp_pkg::V_OVERFLOW;
            end
          end
        end
        omp_pkg::PH_ARGS: begin
          if (cursor_r >= total_r || cursor_r >= omp_pkg::TCNT_W'(omp_pkg::MAX_TAGS)) begin
            phase_nxt = omp_pkg::PH_DONE;
          end else if (tag_rd == omp_pkg::TAG_S) begin
            ev.has_arg = 1'b1;
            if (byte_in == 8'h00) begin
              ev.kind    = omp_pkg::K_STR_END;
              cursor_nxt = cursor_r + 1'b1;
              phase_nxt  = omp_pkg::PH_ARG_PAD;
            end else begin
              ev.kind   = omp_pkg::K_STR_BYTE;
              ev.value  = {24'h0, byte_in};
              phase_nxt = omp_pkg::PH_STRING;
            end
          end else begin
            acc_nxt = {acc_r[23:0], byte_in};
            if (idx == 2'b11) begin
              ev.has_arg = 1'b1;
              ev.kind    = (tag_rd == omp_pkg::TAG_I) ? omp_pkg::K_INT : omp_pkg::K_FLOAT;
              ev.value   = acc_nxt;
              acc_nxt    = '0;
              cursor_nxt = cursor_r + 1'b1;
            end
          end
        end
        omp_pkg::PH_STRING: begin
          ev.has_arg = 1'b1;
          if (byte_in != 8'h00) begin
            ev.kind  = omp_pkg::K_STR_BYTE;
            ev.value = {24'h0, byte_in};
          end else begin
            ev.kind    = omp_pkg::K_STR_END;
            cursor_nxt = cursor_r + 1'b1;
            phase_nxt  = omp_pkg::PH_ARG_PAD;
          end
        end
        default: begin
        end
      endcase
    end

    // Final byte: verdict, then the packet state starts over.
    if (acc_in && eop_in) begin
      ev.has_verd = 1'b1;
      if (bcnt_nxt < omp_pkg::BCNT_W'(4))
        ev.verdict = omp_pkg::V_TOO_SHORT;
      else if (phase_nxt == omp_pkg::PH_ADDR)
        ev.verdict = omp_pkg::V_BAD_ADDR;
      else
        ev.verdict = fault_nxt;
      phase_nxt   = omp_pkg::PH_ADDR;
      bcnt_nxt    = '0;
      total_nxt   = '0;
      cursor_nxt  = '0;
      acc_nxt     = '0;
      addr_ne_nxt = 1'b0;
      fault_nxt   = omp_pkg::V_OK;
    end

    push = acc_in && (ev.has_arg || ev.has_verd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= omp_pkg::PH_ADDR;
      bcnt_r    <= '0;
      total_r   <= '0;
      cursor_r  <= '0;
      acc_r     <= '0;
      addr_ne_r <= 1'b0;
      fault_r   <= omp_pkg::V_OK;
    end else begin
      phase_r   <= phase_nxt;
      bcnt_r    <= bcnt_nxt;
      total_r   <= total_nxt;
      cursor_r  <= cursor_nxt;
      acc_r     <= acc_nxt;
      addr_ne_r <= addr_ne_nxt;
      fault_r   <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_store[total_r[omp_pkg::TIDX_W-1:0]] <= tag_wdata;
  end

endmodule

[rtl/omp_queue.sv]
// Short FIFO of per-byte result entries between front and back end.
// Depends on omp_pkg.
module omp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  omp_pkg::ev_t      wdata,
  input  logic              pop,
  output omp_pkg::ev_t      head,
  output omp_pkg::q_stat_t  stat
);

  omp_pkg::ev_t                mem [omp_pkg::QDEPTH];
  logic [omp_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [omp_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign stat.full  = cnt_r == omp_pkg::QCNT_W'(omp_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

endmodule

[rtl/omp_back.sv]
// Back end: splits queue entries into single results and holds them in
// the output register until transferred. Depends on omp_pkg.
module omp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  omp_pkg::ev_t      head,
  input  omp_pkg::q_stat_t  stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_kind,
  output logic [31:0]       out_value,
  output logic [1:0]        out_verdict,
  output logic              out_run_end
);

  logic            valid_r, valid_nxt;
  logic            half_r, half_nxt;
  omp_pkg::kind_t  kind_r, kind_nxt;
  logic [31:0]     value_r, value_nxt;
  omp_pkg::verd_t  verd_r, verd_nxt;
  logic            end_r, end_nxt;
  logic            load;

  always_comb begin
    load      = !valid_r || !out_stall;
    pop       = 1'b0;
    valid_nxt = valid_r;
    half_nxt  = half_r;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    verd_nxt  = verd_r;
    end_nxt   = end_r;
    if (load) begin
      if (stat.empty) begin
        valid_nxt = 1'b0;
      end else begin
        valid_nxt = 1'b1;
        if (head.has_arg && !half_r) begin
          kind_nxt  = head.kind;
          value_nxt = head.value;
          verd_nxt  = omp_pkg::V_OK;
          end_nxt   = !head.has_verd;
          // Entry with a verdict behind it stays queued until the verdict is loaded.
          if (head.has_verd) half_nxt = 1'b1;
          else pop = 1'b1;
        end else begin
          kind_nxt  = omp_pkg::K_VERDICT;
          value_nxt = '0;
          verd_nxt  = head.verdict;
          end_nxt   = 1'b1;
          half_nxt  = 1'b0;
          pop       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    verd_r  <= verd_nxt;
    end_r   <= end_nxt;
  end

  assign out_valid   = valid_r;
  assign out_kind    = 3'(kind_r);
  assign out_value   = value_r;
  assign out_verdict = 2'(verd_r);
  assign out_run_end = end_r;

endmodule

[rtl/osc_message_parser.sv]
// OSC 1.0 message parser, one packet byte per transfer.
//
// Input channel: in_valid/in_stall with in_packet_byte and in_end_of_packet
// (high on the last byte of a packet). Output channel: out_valid/out_stall
// with out_kind, out_value, out_verdict and out_run_end (high on the last
// result caused by one input byte).
// Throughput: one byte per cycle while in_stall is low. Each byte yields
// zero, one or two results; the output register sends one result per cycle
// while out_stall is low, so a last byte that closes an argument and carries
// the verdict sends both in turn. Each result is queued, then registered.
// A four-entry queue sits between the parser front end and the output stage;
// in_stall rises only while that queue is full, so output stalls back up to
// the input after four entries.
// Reset (rst_n low, synchronous) drops the current packet, empties the queue
// and clears out_valid. Tag storage is not cleared; an entry is read only
// after the current packet has written it. Input is accepted once reset ends.
// Depends on omp_pkg, omp_front, omp_queue, omp_back.
module osc_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_value,
  output logic [1:0]  out_verdict,
  output logic        out_run_end
);

  omp_pkg::ev_t      ev, head;
  omp_pkg::q_stat_t  stat;
  logic              push, pop, acc_in;

  assign in_stall = stat.full;
  assign acc_in   = in_valid && !in_stall;

  omp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_in  (acc_in),
    .byte_in (in_packet_byte),
    .eop_in  (in_end_of_packet),
    .push    (push),
    .ev      (ev)
  );

  omp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (ev),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  omp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_value   (out_value),
    .out_verdict (out_verdict),
    .out_run_end (out_run_end)
  );

endmodule

[rtl/osc_message_parser_chk.sv]
// Port-level checker for osc_message_parser, bound to the top level.
// Depends on omp_pkg and osc_message_parser_assert.svh.
`include "osc_message_parser_assert.svh"

module osc_message_parser_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [31:0] out_value,
  input logic [1:0]  out_verdict,
  input logic        out_run_end
);

  logic is_verd;
  logic is_mark;

  assign is_verd = out_kind == 3'(omp_pkg::K_VERDICT);
  assign is_mark = out_kind == 3'(omp_pkg::K_ADDR_END) || out_kind == 3'(omp_pkg::K_STR_END);

  `OSC_ASSERT_RST(a_reset_idle, clk, !rst_n, !out_valid)
  `OSC_ASSERT_IMP(a_verd_ends_run, clk, rst_n, out_valid && is_verd, out_run_end)
  `OSC_ASSERT_IMP(a_verd_only_final, clk, rst_n, out_valid && !is_verd, out_verdict == 2'd0)
  `OSC_ASSERT_IMP(a_mark_zero, clk, rst_n, out_valid && is_mark, out_value == 32'd0)
  `OSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_kind) && $stable(out_verdict) && $stable(out_run_end))

endmodule

bind osc_message_parser osc_message_parser_chk u_chk (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for osc_message_parser: packets of bytes go in, predicted
// address, argument and verdict results are compared with what comes out.
// Depends on omp_pkg and the osc_message_parser RTL.
module tb_top;

  localparam int RUN_LIMIT  = 1000000;
  localparam int RAND_BYTES = 1900;
  localparam int TAIL_WAIT  = 20;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         drain;
  } pkt_byte_t;

  typedef struct {
    omp_pkg::kind_t kind;
    logic [31:0]    value;
    omp_pkg::verd_t verdict;
    logic           run_end;
  } osc_event_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  in_packet_byte   = 8'h00;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_value;
  logic [1:0]  out_verdict;
  logic        out_run_end;

  pkt_byte_t  byte_queue[$];
  osc_event_t expected_events[$];
  int         errors    = 0;
  int         cycles    = 0;
  int         rx_wait   = 0;
  bit         in_taken  = 1'b0;
  bit         out_taken = 1'b0;

  // parser state mirror
  omp_pkg::phase_t            ps_phase;
  logic [omp_pkg::BCNT_W-1:0] ps_count;
  omp_pkg::tag_t              ps_tags[omp_pkg::MAX_TAGS];
  int                         ps_tag_total;
  int                         ps_tag_cursor;
  logic [31:0]                ps_word;
  bit                         ps_addr_seen;
  omp_pkg::verd_t             ps_fault;

  osc_message_parser dut (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_packet_state();
    ps_phase      = omp_pkg::PH_ADDR;
    ps_count      = '0;
    ps_tag_total  = 0;
    ps_tag_cursor = 0;
    ps_word       = '0;
    ps_addr_seen  = 1'b0;
    ps_fault      = omp_pkg::V_OK;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eop);
    osc_event_t     batch[$];
    logic [1:0]     pos;
    omp_pkg::tag_t  t;
    omp_pkg::verd_t v;
    if (ps_count < omp_pkg::MAX_PACKET_BYTES) begin
      pos = ps_count[1:0];
      ps_count = ps_count + 1'b1;
      if (ps_phase == omp_pkg::PH_ADDR_PAD && pos == 2'd0) ps_phase = omp_pkg::PH_COMMA;
      if (ps_phase == omp_pkg::PH_ARG_PAD && pos == 2'd0) ps_phase = omp_pkg::PH_ARGS;
      case (ps_phase)
        omp_pkg::PH_ADDR: begin
          if (b != 8'h00) begin
            batch.push_back('{omp_pkg::K_ADDR_BYTE, {24'd0, b}, omp_pkg::V_OK, 1'b0});
            ps_addr_seen = 1'b1;
          end else if (!ps_addr_seen) begin
            ps_fault = omp_pkg::V_BAD_ADDR;
            ps_phase = omp_pkg::PH_DONE;
          end else begin
            batch.push_back('{omp_pkg::K_ADDR_END, 32'd0, omp_pkg::V_OK, 1'b0});
            ps_phase = omp_pkg::PH_ADDR_PAD;
          end
        end
        omp_pkg::PH_COMMA:
          ps_phase = (b == omp_pkg::CH_COMMA) ? omp_pkg::PH_TAGS : omp_pkg::PH_DONE;
        omp_pkg::PH_TAGS: begin
          if (b == 8'h00) begin
            ps_phase = omp_pkg::PH_ARG_PAD;
          end else if (b == omp_pkg::CH_I || b == omp_pkg::CH_F || b == omp_pkg::CH_S) begin
            if (ps_tag_total < omp_pkg::MAX_TAGS) begin
              ps_tags[ps_tag_total] = (b == omp_pkg::CH_I) ? omp_pkg::TAG_I :
                                      (b == omp_pkg::CH_F) ? omp_pkg::TAG_F : omp_pkg::TAG_S;
              ps_tag_total++;
            end else if (ps_fault == omp_pkg::V_OK) begin
              ps_fault = omp_pkg::V_OVERFLOW;
            end
          end
        end
        omp_pkg::PH_ARGS: begin
          if (ps_tag_cursor >= ps_tag_total) begin
            ps_phase = omp_pkg::PH_DONE;
          end else begin
            t = ps_tags[ps_tag_cursor];
            if (t == omp_pkg::TAG_S) begin
              if (b == 8'h00) begin
                batch.push_back('{omp_pkg::K_STR_END, 32'd0, omp_pkg::V_OK, 1'b0});
                ps_tag_cursor++;
                ps_phase = omp_pkg::PH_ARG_PAD;
              end else begin
                batch.push_back('{omp_pkg::K_STR_BYTE, {24'd0, b}, omp_pkg::V_OK, 1'b0});
                ps_phase = omp_pkg::PH_STRING;
              end
            end else begin
              ps_word = {ps_word[23:0], b};
              if (pos == 2'd3) begin
                batch.push_back('{(t == omp_pkg::TAG_I) ? omp_pkg::K_INT : omp_pkg::K_FLOAT,
                                  ps_word, omp_pkg::V_OK, 1'b0});
                ps_word = '0;
                ps_tag_cursor++;
              end
            end
          end
        end
        omp_pkg::PH_STRING: begin
          if (b != 8'h00) begin
            batch.push_back('{omp_pkg::K_STR_BYTE, {24'd0, b}, omp_pkg::V_OK, 1'b0});
          end else begin
            batch.push_back('{omp_pkg::K_STR_END, 32'd0, omp_pkg::V_OK, 1'b0});
            ps_tag_cursor++;
            ps_phase = omp_pkg::PH_ARG_PAD;
          end
        end
        default: ;
      endcase
    end
    if (eop) begin
      if (ps_count < 4) v = omp_pkg::V_TOO_SHORT;
      else if (ps_phase == omp_pkg::PH_ADDR) v = omp_pkg::V_BAD_ADDR;
      else v = ps_fault;
      batch.push_back('{omp_pkg::K_VERDICT, 32'd0, v, 1'b0});
      clear_packet_state();
    end
    if (batch.size() > 0) batch[batch.size() - 1].run_end = 1'b1;
    foreach (batch[i]) expected_events.push_back(batch[i]);
  endtask

  // stimulus helpers
  task automatic put_text(ref logic [7:0] pkt[$], input string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endtask

  task automatic put_word(ref logic [7:0] pkt[$], input logic [31:0] w);
    pkt.push_back(w[31:24]);
    pkt.push_back(w[23:16]);
    pkt.push_back(w[15:8]);
    pkt.push_back(w[7:0]);
  endtask

  task automatic pad4(ref logic [7:0] pkt[$]);
    while (pkt.size() % 4 != 0) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic queue_packet(ref logic [7:0] pkt[$], input int gap_max, input bit drain_first);
    pkt_byte_t item;
    foreach (pkt[i]) begin
      item.data  = pkt[i];
      item.last  = (i == pkt.size() - 1);
      item.gap   = $urandom_range(0, gap_max);
      item.drain = drain_first && (i == 0);
      byte_queue.push_back(item);
    end
    pkt.delete();
  endtask

  task automatic build_message(ref logic [7:0] pkt[$]);
    logic [7:0] tags[$];
    int         n_addr;
    int         n_tags;
    int         kept;
    int         r;
    int         cut;
    n_addr = $urandom_range(0, 9);
    for (int i = 0; i <= n_addr; i++) pkt.push_back(8'($urandom_range(1, 255)));
    pkt.push_back(8'h00);
    pad4(pkt);
    r = $urandom_range(0, 19);
    if (r == 1) begin
      pkt.push_back(8'($urandom_range(0, 255)));
      pad4(pkt);
    end else if (r > 1) begin
      n_tags = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
      for (int i = 0; i < n_tags; i++) begin
        r = $urandom_range(0, 19);
        if (r < 8) tags.push_back(omp_pkg::CH_I);
        else if (r < 12) tags.push_back(omp_pkg::CH_F);
        else if (r < 17) tags.push_back(omp_pkg::CH_S);
        else tags.push_back(8'($urandom_range(1, 255)));
      end
      pkt.push_back(omp_pkg::CH_COMMA);
      foreach (tags[i]) pkt.push_back(tags[i]);
      pkt.push_back(8'h00);
      pad4(pkt);
      kept = 0;
      foreach (tags[i]) begin
        if (kept < omp_pkg::MAX_TAGS && (tags[i] == omp_pkg::CH_I ||
            tags[i] == omp_pkg::CH_F || tags[i] == omp_pkg::CH_S)) begin
          kept++;
          if (tags[i] == omp_pkg::CH_S) begin
            repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom_range(1, 255)));
            pkt.push_back(8'h00);
            pad4(pkt);
          end else begin
            put_word(pkt, $urandom());
          end
        end
      end
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom_range(0, 255)));
    // cut the packet short somewhere inside
    if ($urandom_range(0, 9) < 3 && pkt.size() > 1) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  // transfer bookkeeping, prediction and checking
  always @(posedge clk) begin
    osc_event_t want;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (in_taken) parse_byte(in_packet_byte, in_end_of_packet);
    if (out_taken) begin
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind=%0d value=%h verdict=%0d run_end=%0d",
                   out_kind, out_value, out_verdict, out_run_end);
      end else begin
        want = expected_events.pop_front();
        if (out_kind !== want.kind || out_value !== want.value ||
            out_verdict !== want.verdict || out_run_end !== want.run_end) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected kind=%0d value=%h verdict=%0d run_end=%0d, %s",
                     want.kind, want.value, want.verdict, want.run_end,
                     $sformatf("got kind=%0d value=%h verdict=%0d run_end=%0d",
                               out_kind, out_value, out_verdict, out_run_end));
        end
      end
    end
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // byte driver
  always @(negedge clk) begin
    pkt_byte_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (byte_queue[0].gap > 0) begin
        byte_queue[0].gap = byte_queue[0].gap - 1;
        in_valid <= 1'b0;
      end else if (byte_queue[0].drain && expected_events.size() > 0) begin
        in_valid <= 1'b0;
      end else begin
        cur = byte_queue.pop_front();
        in_valid         <= 1'b1;
        in_packet_byte   <= cur.data;
        in_end_of_packet <= cur.last;
      end
    end
  end

  // result receiver: stall drawn per transfer, quiet stretches every so often
  always @(negedge clk) begin
    if (out_taken) rx_wait = (((cycles / 2000) % 4) == 3) ? 0 : $urandom_range(0, 4);
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [7:0] pkt[$];
    int         rand_bytes;
    int         gap_max;
    int         r;
    clear_packet_state();

    // packet shorter than four bytes
    put_text(pkt, "/");
    queue_packet(pkt, 4, 1'b0);
    // empty address
    pkt = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    queue_packet(pkt, 4, 1'b0);
    // address never terminated
    put_text(pkt, "/ab");
    pkt.push_back(8'hFF);
    queue_packet(pkt, 4, 1'b0);
    // ends before the type tag
    put_text(pkt, "/a");
    put_word(pkt, 32'd0);
    void'(pkt.pop_back());
    void'(pkt.pop_back());
    queue_packet(pkt, 4, 1'b0);
    // boundary byte is not a comma
    put_text(pkt, "/a");
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    put_text(pkt, "!");
    queue_packet(pkt, 4, 1'b0);
    // every argument kind, an unknown tag, trailing bytes
    put_text(pkt, "/a");
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    put_text(pkt, ",ixfs");
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    put_word(pkt, 32'h8000_0000);
    put_word(pkt, 32'hFFFF_FFFF);
    put_text(pkt, "q");
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    pkt.push_back(8'h55);
    queue_packet(pkt, 4, 1'b0);
    // int cut off, second tag past the end
    put_text(pkt, "/a");
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    put_text(pkt, ",ii");
    pkt.push_back(8'h00);
    pkt.push_back(8'h01);
    pkt.push_back(8'h02);
    queue_packet(pkt, 4, 1'b0);
    // string cut off
    put_text(pkt, "/a");
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    put_text(pkt, ",s");
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    put_text(pkt, "zz");
    queue_packet(pkt, 4, 1'b0);
    // more tags than can be stored
    put_text(pkt, "/a");
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    put_text(pkt, ",iiiiiiiiiiiiiiiii");
    while (pkt.size() < 24) pkt.push_back(8'h00);
    put_word(pkt, 32'h0123_4567);
    queue_packet(pkt, 4, 1'b0);

    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        build_message(pkt);
      end else if (r < 17) begin
        repeat ($urandom_range(1, 10))
          pkt.push_back(($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom_range(0, 255)));
      end else if (r < 18) begin
        repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
      end else begin
        pkt.push_back(8'h00);
        repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom_range(0, 255)));
      end
      rand_bytes += pkt.size();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      queue_packet(pkt, gap_max, rand_bytes < 40 || $urandom_range(0, 39) == 0);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (byte_queue.size() == 0 && !in_valid && expected_events.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
